### rtl/fat12_cluster_chain_walker_macros.svh
// Assertion macros shared by the cluster chain walker RTL.
// Depends on nothing; the asserting modules need ports clk_i and rst_ni.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define FCCW_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fccw assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define FCCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fccw assertion failed");
`else
`define FCCW_ASSERT(lbl, ante, cons)
`define FCCW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/fccw_pkg.sv
// Shared types, codes and helpers of the FAT12 cluster chain walker.
// Used by fccw_ctrl, fccw_dpath and fat12_cluster_chain_walker.
package fccw_pkg;

  localparam int unsigned TableBytes = 8192;
  localparam int unsigned TabAw      = $clog2(TableBytes);
  localparam int unsigned OffW       = 14;   // byte offset of an entry plus one
  localparam int unsigned ClusterW   = 12;
  localparam int unsigned LbaW       = 20;

  localparam logic [ClusterW-1:0] EndMark = 12'hFF8;
  localparam logic [LbaW-1:0]     LbaMax  = 20'hFFFFF;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_START   = 2'd1,
    KIND_ADVANCE = 2'd2
  } kind_e;

  typedef enum logic [0:0] {
    CFG_DATA_REGION_LBA     = 1'b0,
    CFG_SECTORS_PER_CLUSTER = 1'b1
  } cfg_idx_e;

  // Controller to datapath.
  typedef struct packed {
    logic table_write;  // write the load byte into the table
    logic walk_start;   // latch the visited cluster and read its low byte
    logic read_hi;      // read the high byte, keep the low one
    logic out_load;     // publish the result and advance the chain
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;     // output register empty or being drained
  } dp_status_t;

  // Byte offset of a 12-bit entry: cluster * 3 / 2.
  function automatic logic [OffW-1:0] entry_offset(input logic [ClusterW-1:0] cluster);
    logic [OffW-1:0] triple;
    triple = OffW'(cluster) * OffW'(3);
    return triple >> 1;
  endfunction

endpackage

### rtl/fat12_cluster_chain_walker.sv
// Top level of the FAT12 cluster chain walker: ports, controller and datapath.
// Depends on fccw_pkg, fccw_ctrl and fccw_dpath.
//
// The block keeps a FAT12 allocation table in an on-chip byte memory and
// follows cluster chains through it. Items arrive on the s_axis channel;
// tuser carries the item kind. A load transaction writes one table byte and
// produces nothing. A start transaction visits the cluster in tdata, an
// advance transaction visits the cluster that the previous visit returned.
// Each visit produces one m_axis transaction: the cluster's first sector
// and its table entry in tdata, tlast when the entry marks the chain end,
// and tuser when the visited cluster number is below two.
// A load is written into the table as it is accepted. A walk is paced by the
// single memory port reading the entry's two bytes one after the other:
// s_axis_tready stays low through the read-high and finish steps after
// acceptance, and the result register loads in the finish step.
// If the receiver stalls, the finished result waits in the output register;
// the next item is still accepted, and a further walk holds in its last
// step until the register drains. After reset the table contents are
// undefined until loaded, the current cluster is zero, data_region_lba is
// 33 and sectors_per_cluster is 1. Config writes are taken whenever
// cfg_we_i is high and belong to idle periods.
module fat12_cluster_chain_walker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // table_address[12:0], table_byte[20:13],
                                      // start_cluster[32:21], zero fill above
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // sector_lba[19:0], following_cluster[31:20]
  output logic        m_axis_tlast,   // chain_end
  output logic [0:0]  m_axis_tuser,   // bad_cluster[0]
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  fccw_pkg::dp_cmd_t             cmd;
  fccw_pkg::dp_status_t          status;
  logic [fccw_pkg::LbaW-1:0]     sector_lba;
  logic [fccw_pkg::ClusterW-1:0] following_cluster;
  logic                          chain_end;
  logic                          bad_cluster;

  // The controller only decides when the memory port and output register move.
  fccw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .kind_i     (s_axis_tuser),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the table, the config registers and the result.
  fccw_dpath u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .kind_i              (s_axis_tuser),
    .table_address_i     (s_axis_tdata[12:0]),
    .table_byte_i        (s_axis_tdata[20:13]),
    .start_cluster_i     (s_axis_tdata[32:21]),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .out_valid_o         (m_axis_tvalid),
    .out_ready_i         (m_axis_tready),
    .sector_lba_o        (sector_lba),
    .following_cluster_o (following_cluster),
    .chain_end_o         (chain_end),
    .bad_cluster_o       (bad_cluster)
  );

  assign m_axis_tdata    = {following_cluster, sector_lba};
  assign m_axis_tlast    = chain_end;
  assign m_axis_tuser[0] = bad_cluster;

endmodule

### rtl/fccw_dpath.sv
// Datapath of the cluster chain walker: table memory, config, LBA math, output register.
// Depends on fccw_pkg and fat12_cluster_chain_walker_macros.svh.
`include "fat12_cluster_chain_walker_macros.svh"
module fccw_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fccw_pkg::dp_cmd_t               cmd_i,
  output fccw_pkg::dp_status_t            status_o,
  input  logic [1:0]                      kind_i,
  input  logic [12:0]                     table_address_i,
  input  logic [7:0]                      table_byte_i,
  input  logic [fccw_pkg::ClusterW-1:0]   start_cluster_i,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_index_i,
  input  logic [15:0]                     cfg_wdata_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fccw_pkg::LbaW-1:0]       sector_lba_o,
  output logic [fccw_pkg::ClusterW-1:0]   following_cluster_o,
  output logic                            chain_end_o,
  output logic                            bad_cluster_o
);

  logic [7:0]                    table_mem [fccw_pkg::TableBytes];
  logic [7:0]                    rdata_q;
  logic                          rd_in_range_q;
  logic [7:0]                    lo_q;
  logic [15:0]                   data_lba_q;
  logic [7:0]                    spc_q;
  logic [fccw_pkg::ClusterW-1:0] cur_q, cur_d;
  logic [fccw_pkg::ClusterW-1:0] visit_q;
  logic [fccw_pkg::LbaW-1:0]     prod_q;
  logic                          out_valid_q;
  logic [fccw_pkg::LbaW-1:0]     lba_q;
  logic [fccw_pkg::ClusterW-1:0] next_q;
  logic                          end_q, bad_q;

  logic [fccw_pkg::ClusterW-1:0] walk_cluster;
  logic [fccw_pkg::OffW-1:0]     addr;
  logic                          addr_in_range;
  logic                          mem_re;
  logic [7:0]                    rd_byte;
  logic [15:0]                   word;
  logic [fccw_pkg::LbaW:0]       lba_sum;
  logic [fccw_pkg::LbaW-1:0]     lba_d;

  assign walk_cluster = (kind_i == fccw_pkg::KIND_START) ? start_cluster_i : cur_q;

  // One port: load writes, walk reads the low byte, then the high byte.
  always_comb begin
    priority if (cmd_i.table_write) begin
      addr = {1'b0, table_address_i};
    end else if (cmd_i.walk_start) begin
      addr = fccw_pkg::entry_offset(walk_cluster);
    end else begin
      addr = fccw_pkg::entry_offset(visit_q) + fccw_pkg::OffW'(1);
    end
  end

  assign addr_in_range = addr < fccw_pkg::OffW'(fccw_pkg::TableBytes);
  assign mem_re        = cmd_i.walk_start | cmd_i.read_hi;

  always_ff @(posedge clk_i) begin
    if (cmd_i.table_write && addr_in_range) begin
      table_mem[addr[fccw_pkg::TabAw-1:0]] <= table_byte_i;
    end
    if (mem_re) begin
      rdata_q       <= table_mem[addr[fccw_pkg::TabAw-1:0]];
      rd_in_range_q <= addr_in_range;
    end
  end

  // Bytes past the end of the table read as zero.
  assign rd_byte = rd_in_range_q ? rdata_q : 8'h00;

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      visit_q <= walk_cluster;
    end
    if (cmd_i.read_hi) begin
      lo_q   <= rd_byte;
      prod_q <= fccw_pkg::LbaW'(visit_q - fccw_pkg::ClusterW'(2)) * fccw_pkg::LbaW'(spc_q);
    end
  end

  assign word    = {rd_byte, lo_q};
  assign cur_d   = visit_q[0] ? word[15:4] : word[11:0];
  assign lba_sum = (fccw_pkg::LbaW+1)'(data_lba_q) + (fccw_pkg::LbaW+1)'(prod_q);

  always_comb begin
    priority if (visit_q < fccw_pkg::ClusterW'(2)) begin
      lba_d = '0;
    end else if (lba_sum[fccw_pkg::LbaW]) begin
      lba_d = fccw_pkg::LbaMax;
    end else begin
      lba_d = lba_sum[fccw_pkg::LbaW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_lba_q  <= 16'd33;
      spc_q       <= 8'd1;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (fccw_pkg::cfg_idx_e'(cfg_index_i))
          fccw_pkg::CFG_DATA_REGION_LBA:     data_lba_q <= cfg_wdata_i;
          fccw_pkg::CFG_SECTORS_PER_CLUSTER: spc_q      <= cfg_wdata_i[7:0];
          default:                           data_lba_q <= data_lba_q;
        endcase
      end
      if (cmd_i.out_load) begin
        cur_q       <= cur_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      lba_q  <= lba_d;
      next_q <= cur_d;
      end_q  <= cur_d >= fccw_pkg::EndMark;
      bad_q  <= visit_q < fccw_pkg::ClusterW'(2);
    end
  end

  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign sector_lba_o        = lba_q;
  assign following_cluster_o = next_q;
  assign chain_end_o         = end_q;
  assign bad_cluster_o       = bad_q;

  `FCCW_ASSERT(a_port_single_use, cmd_i.table_write, !(cmd_i.walk_start || cmd_i.read_hi))
  `FCCW_ASSERT_NEXT(a_load_shows_result, cmd_i.out_load, out_valid_q && cur_q == next_q)

endmodule

### rtl/fccw_ctrl.sv
// Controller of the cluster chain walker: sequences table reads and result hand-off.
// Depends on fccw_pkg and fat12_cluster_chain_walker_macros.svh.
`include "fat12_cluster_chain_walker_macros.svh"
module fccw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           kind_i,
  input  fccw_pkg::dp_status_t status_i,
  output fccw_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_HI,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   is_walk;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_walk    = (kind_i == fccw_pkg::KIND_START) || (kind_i == fccw_pkg::KIND_ADVANCE);

  always_comb begin
    cmd_o.table_write = accept && (kind_i == fccw_pkg::KIND_LOAD);
    cmd_o.walk_start  = accept && is_walk;
    cmd_o.read_hi     = (state_q == ST_READ_HI);
    cmd_o.out_load    = (state_q == ST_FINISH) && status_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (cmd_o.walk_start) state_d = ST_READ_HI;
      ST_READ_HI: state_d = ST_FINISH;
      ST_FINISH:  if (status_i.out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `FCCW_ASSERT_NEXT(a_walk_reads_hi, cmd_o.walk_start, state_q == ST_READ_HI)
  `FCCW_ASSERT_NEXT(a_hi_then_finish, state_q == ST_READ_HI, state_q == ST_FINISH)
  `FCCW_ASSERT_NEXT(a_stall_holds, (state_q == ST_FINISH) && !status_i.out_free,
                    state_q == ST_FINISH)

endmodule

### tb/sv/walk_check_pkg.sv
// Scoreboard for the FAT12 cluster chain walker: a predictor of table loads and chain walks,
// and the queue of cluster visits it expects. Depends on fccw_pkg for widths and item codes.
package walk_check_pkg;
  import fccw_pkg::*;

  typedef struct packed {
    logic [LbaW-1:0]     sector_lba;
    logic [ClusterW-1:0] following_cluster;
    logic                chain_end;
    logic                bad_cluster;
  } cluster_visit_t;

  class walk_scoreboard;
    logic [7:0]          fat_bytes [TableBytes];
    bit                  fat_loaded [TableBytes];
    logic [ClusterW-1:0] chain_cursor;
    logic [15:0]         region_lba;
    logic [7:0]          cluster_sectors;
    cluster_visit_t      expected_visits [$];
    int unsigned         fails;

    function new();
      foreach (fat_loaded[i]) fat_loaded[i] = 1'b0;
      chain_cursor    = '0;
      region_lba      = 16'd33;
      cluster_sectors = 8'd1;
      fails           = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] value);
      case (idx)
        CFG_DATA_REGION_LBA:     region_lba = value;
        CFG_SECTORS_PER_CLUSTER: cluster_sectors = value[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_visits.size();
    endfunction

    // Visits one cluster: its first sector, its table entry, and the chain moves on.
    function void visit_cluster(logic [ClusterW-1:0] cluster);
      cluster_visit_t v;
      logic [31:0]    sum;
      int unsigned    at;
      logic [15:0]    word;
      v.bad_cluster = (cluster < 2);
      v.sector_lba  = '0;
      if (!v.bad_cluster) begin
        sum = 32'(region_lba) + (32'(cluster) - 32'd2) * 32'(cluster_sectors);
        v.sector_lba = (sum > 32'(LbaMax)) ? LbaMax : sum[LbaW-1:0];
      end
      at   = (32'(cluster) * 3) / 2;
      word = {fat_bytes[at + 1], fat_bytes[at]};
      v.following_cluster = cluster[0] ? word[15:4] : word[11:0];
      v.chain_end         = (v.following_cluster >= EndMark);
      chain_cursor        = v.following_cluster;
      expected_visits.push_back(v);
    endfunction

    function void accept_item(logic [1:0] kind, logic [12:0] addr, logic [7:0] data,
                              logic [ClusterW-1:0] start);
      case (kind)
        KIND_LOAD: begin
          if (addr < TableBytes) begin
            fat_bytes[addr]  = data;
            fat_loaded[addr] = 1'b1;
          end
        end
        KIND_START:   visit_cluster(start);
        KIND_ADVANCE: visit_cluster(chain_cursor);
        default: ;
      endcase
    endfunction

    function void check_visit(cluster_visit_t got);
      cluster_visit_t exp;
      if (expected_visits.size() == 0) begin
        $error("unexpected visit result: lba %0h next %0h", got.sector_lba,
               got.following_cluster);
        fails++;
        return;
      end
      exp = expected_visits.pop_front();
      if (got.sector_lba !== exp.sector_lba) begin
        $error("sector_lba: expected %0h, got %0h", exp.sector_lba, got.sector_lba);
        fails++;
      end
      if (got.following_cluster !== exp.following_cluster) begin
        $error("following_cluster: expected %0h, got %0h", exp.following_cluster,
               got.following_cluster);
        fails++;
      end
      if (got.chain_end !== exp.chain_end) begin
        $error("chain_end: expected %0b, got %0b", exp.chain_end, got.chain_end);
        fails++;
      end
      if (got.bad_cluster !== exp.bad_cluster) begin
        $error("bad_cluster: expected %0b, got %0b", exp.bad_cluster, got.bad_cluster);
        fails++;
      end
    endfunction
  endclass

endpackage

### tb/sv/tb_top.sv
// Top-level testbench of the FAT12 cluster chain walker: clock, reset, stimulus and checking.
// Depends on fccw_pkg, walk_check_pkg and the fat12_cluster_chain_walker RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fccw_pkg::*;
  import walk_check_pkg::*;

  // The item code that the block ignores.
  localparam logic [1:0] KindUnused = 2'd3;
  // Cycles to let pass after the last result before touching the registers,
  // enough for any walk or load still in flight to finish.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ItemsPerPhase = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [15:0] cfg_wdata_i;

  walk_scoreboard sb;
  int unsigned    items_sent;
  // While a side is calm it never idles, so back-to-back stretches occur too.
  bit             tx_calm;
  bit             rx_calm;

  fat12_cluster_chain_walker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Sends one item as a single input transaction. Inputs change on the falling
  // edge; the transaction counts at the rising edge where tready is seen high,
  // and only then does the scoreboard learn about it. tvalid stays high until
  // the next falling edge, where it either drops for a gap or carries the next item.
  task automatic send_item(logic [1:0] kind, logic [12:0] addr, logic [7:0] data,
                           logic [11:0] start);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'd0, start, data, addr};
    s_axis_tuser  = kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.accept_item(kind, addr, data, start);
    if (kind != KindUnused) items_sent++;
  endtask

  // A load transaction; the unused cluster field carries random bits.
  task automatic put_byte(int unsigned addr, logic [7:0] data);
    send_item(KIND_LOAD, 13'(addr), data, 12'($urandom));
  endtask

  // Writes the 12-bit entry of a cluster. The byte it shares with the
  // neighboring entry keeps its other nibble, or gets random bits if it was
  // never loaded.
  task automatic set_entry(logic [11:0] cluster, logic [11:0] entry);
    int unsigned at;
    logic [7:0]  lo;
    logic [7:0]  hi;
    at = (32'(cluster) * 3) / 2;
    lo = sb.fat_loaded[at] ? sb.fat_bytes[at] : 8'($urandom);
    hi = sb.fat_loaded[at + 1] ? sb.fat_bytes[at + 1] : 8'($urandom);
    if (!cluster[0]) begin
      lo      = entry[7:0];
      hi[3:0] = entry[11:8];
    end else begin
      lo[7:4] = entry[3:0];
      hi      = entry[11:4];
    end
    if ($urandom_range(0, 1) != 0) begin
      put_byte(at, lo);
      put_byte(at + 1, hi);
    end else begin
      put_byte(at + 1, hi);
      put_byte(at, lo);
    end
  endtask

  // The table is undefined until loaded, so a walk never reaches a byte that
  // was not written: any missing byte of the entry is loaded first.
  task automatic cover_entry(logic [11:0] cluster);
    int unsigned at;
    at = (32'(cluster) * 3) / 2;
    if (!sb.fat_loaded[at]) put_byte(at, 8'($urandom));
    if (!sb.fat_loaded[at + 1]) put_byte(at + 1, 8'($urandom));
  endtask

  task automatic walk_start(logic [11:0] cluster);
    cover_entry(cluster);
    send_item(KIND_START, 13'($urandom), 8'($urandom), cluster);
  endtask

  task automatic walk_advance();
    cover_entry(sb.chain_cursor);
    send_item(KIND_ADVANCE, 13'($urandom), 8'($urandom), 12'($urandom));
  endtask

  // Mostly ordinary data clusters, with the bad ones and the top of the range
  // drawn often enough to matter.
  function automatic logic [11:0] pick_cluster();
    case ($urandom_range(0, 9))
      0:       return 12'($urandom_range(0, 1));
      1:       return 12'($urandom_range(4090, 4095));
      default: return 12'($urandom_range(2, 4095));
    endcase
  endfunction

  // Builds a chain in the table, starts a walk at its head and follows it,
  // sometimes past its end. The tail usually holds an end marker.
  task automatic follow_chain();
    logic [11:0] links [6];
    logic [11:0] tail;
    int unsigned len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) links[i] = pick_cluster();
    tail = ($urandom_range(0, 3) == 0) ? 12'($urandom) : EndMark + 12'($urandom_range(0, 7));
    for (int i = 0; i < len - 1; i++) set_entry(links[i], links[i + 1]);
    set_entry(links[len - 1], tail);
    walk_start(links[0]);
    repeat (len - 1 + $urandom_range(0, 2)) walk_advance();
  endtask

  task automatic run_random(int unsigned goal);
    int unsigned pick;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        follow_chain();
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 6)) put_byte($urandom_range(0, TableBytes - 1), 8'($urandom));
      end else if (pick < 85) begin
        walk_start(pick_cluster());
      end else if (pick < 95) begin
        walk_advance();
      end else begin
        send_item(KindUnused, 13'($urandom), 8'($urandom), 12'($urandom));
      end
    end
  endtask

  // Waits until every expected visit has come back, then lets the block
  // finish any load still in flight, since loads produce no result.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_reg(cfg_idx_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 16'($urandom);
    sb.set_reg(idx, value);
  endtask

  // Main sequence: reset, a directed opening with the reset register values,
  // then random phases, each with its own register setting.
  initial begin
    logic [15:0] region;
    logic [7:0]  sectors;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_wdata_i   = '0;
    items_sent    = 0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    sb            = new();
    rst_ni        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening. The first advance follows the reset cursor, cluster zero.
    walk_advance();
    set_entry(12'd2, 12'd3);
    set_entry(12'd3, 12'hFFF);
    walk_start(12'd2);
    walk_advance();
    // One step past the end visits the end marker itself.
    walk_advance();
    walk_start(12'd0);
    walk_start(12'd1);
    walk_start(12'hFFF);
    // The chain end flag switches between these two entry values.
    set_entry(12'd4, EndMark - 12'd1);
    walk_start(12'd4);
    set_entry(12'd5, EndMark);
    walk_start(12'd5);
    put_byte(TableBytes - 1, 8'hFF);
    send_item(KindUnused, '1, '1, '1);
    send_item(KindUnused, '0, '0, '0);
    run_random(ItemsPerPhase);

    // Register phases: smallest values, largest values where the sector
    // number saturates, a cluster size of zero, then ordinary settings.
    for (int phase = 1; phase <= 5; phase++) begin
      settle();
      case (phase)
        1: begin region = 16'd0; sectors = 8'd1; end
        2: begin region = 16'hFFFF; sectors = 8'hFF; end
        3: begin region = 16'($urandom); sectors = 8'd0; end
        4: begin region = 16'($urandom); sectors = 8'd128; end
        default: begin region = 16'($urandom); sectors = 8'($urandom_range(1, 128)); end
      endcase
      if ($urandom_range(0, 1) != 0) begin
        program_reg(CFG_DATA_REGION_LBA, region);
        program_reg(CFG_SECTORS_PER_CLUSTER, {8'($urandom), sectors});
      end else begin
        program_reg(CFG_SECTORS_PER_CLUSTER, {8'($urandom), sectors});
        program_reg(CFG_DATA_REGION_LBA, region);
      end
      run_random(ItemsPerPhase * (phase + 1));
    end

    // Drain: every visit must come back, then a quiet tail for stray results.
    settle();
    repeat (20) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("[fat12_cluster_chain_walker] OK");
    end else begin
      $display("[fat12_cluster_chain_walker] ERROR");
    end
    $finish;
  end

  // Result side: each result transaction is preceded by a random stall with
  // tready low. The outputs are read at the rising edge that completes the
  // transaction, before the block updates them.
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      sb.check_visit({m_axis_tdata[19:0], m_axis_tdata[31:20], m_axis_tlast, m_axis_tuser[0]});
    end
  end

  // Watchdog: the slowest correct run stays well below this.
  initial begin
    #4_000_000;
    $display("[fat12_cluster_chain_walker] ERROR");
    $finish;
  end

endmodule
